FILE: sv/rc_servo_frame_parser_unit_macros.svh
// Assertion macros for the RC servo frame parser.
// Used by the checker file; depends on nothing else.
`ifndef RC_SERVO_FRAME_PARSER_UNIT_MACROS_SVH
`define RC_SERVO_FRAME_PARSER_UNIT_MACROS_SVH

// Assertion clocked on clk and switched off while reset is asserted.
`define RSFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion clocked on clk that is also checked during reset.
`define RSFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/rsfp_pkg.sv
// Shared types and constants for the RC servo frame parser.
// Used by every module of the block; depends on nothing.
package rsfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned CH_W   = 4;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned ST_W   = 2;

  localparam logic [BYTE_W-1:0] HDR_LEN  = 8'h20;
  localparam logic [BYTE_W-1:0] HDR_TYPE = 8'h40;
  localparam logic [SUM_W-1:0]  SUM_INIT = 16'hFFFF;

  localparam logic [ST_W-1:0] ST_BUSY  = 2'd0;
  localparam logic [ST_W-1:0] ST_READY = 2'd1;
  localparam logic [ST_W-1:0] ST_ERROR = 2'd2;

  typedef enum logic [1:0] {
    CMD_BUSY    = 2'd0,
    CMD_ERROR   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] data;
  } wr_port_t;

endpackage

FILE: sv/rsfp_front.sv
// Front end of the frame parser: accepts bytes, tracks the frame and checksum.
// Writes channel words to the back end and pushes one command per byte. Uses rsfp_pkg.
module rsfp_front #(
  parameter int unsigned CHANNELS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rsfp_pkg::BYTE_W-1:0] in_byte,
  input  logic                       q_full,
  output logic                       push,
  output rsfp_pkg::cmd_t             push_cmd,
  output rsfp_pkg::wr_port_t         wr,
  input  logic                       rel_done
);

  localparam logic [rsfp_pkg::CNT_W-1:0] PAY_LAST = rsfp_pkg::CNT_W'(2 * CHANNELS - 1);

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_SUM  = 4'b1000
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [rsfp_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [rsfp_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [rsfp_pkg::BYTE_W-1:0]   low_r, low_nxt;
  logic                          rel_pend_r, rel_pend_nxt;
  logic                          acc;
  logic [rsfp_pkg::SUM_W-1:0]    sum_sub;
  logic [rsfp_pkg::VAL_W-1:0]    word;

  assign in_ready = !rel_pend_r && !q_full;
  assign acc      = in_valid && in_ready;
  assign push     = acc;
  assign sum_sub  = sum_r - rsfp_pkg::SUM_W'(in_byte);
  assign word     = {in_byte, low_r};

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    low_nxt      = low_r;
    rel_pend_nxt = rel_pend_r;
    push_cmd     = rsfp_pkg::CMD_BUSY;
    wr.we        = 1'b0;
    wr.ch        = count_r[rsfp_pkg::CH_W:1];
    wr.data      = word;
    if (rel_done) begin
      rel_pend_nxt = 1'b0;
    end
    if (acc) begin
      case (phase_r)
        PH_LEN: begin
          if (in_byte != rsfp_pkg::HDR_LEN) begin
            push_cmd = rsfp_pkg::CMD_ERROR;
            count_nxt = '0;
            sum_nxt   = rsfp_pkg::SUM_INIT;
          end else begin
            sum_nxt   = sum_sub;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (in_byte != rsfp_pkg::HDR_TYPE) begin
            push_cmd  = rsfp_pkg::CMD_ERROR;
            phase_nxt = PH_LEN;
            count_nxt = '0;
            sum_nxt   = rsfp_pkg::SUM_INIT;
          end else begin
            sum_nxt   = sum_sub;
            phase_nxt = PH_PAY;
            count_nxt = '0;
          end
        end
        PH_PAY: begin
          sum_nxt = sum_sub;
          if (!count_r[0]) begin
            low_nxt = in_byte;
          end else begin
            wr.we = 1'b1;
          end
          if (count_r >= PAY_LAST) begin
            phase_nxt = PH_SUM;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        PH_SUM: begin
          if (count_r == '0) begin
            low_nxt   = in_byte;
            count_nxt = rsfp_pkg::CNT_W'(1);
          end else begin
            phase_nxt = PH_LEN;
            count_nxt = '0;
            sum_nxt   = rsfp_pkg::SUM_INIT;
            if (word == sum_r) begin
              push_cmd     = rsfp_pkg::CMD_RELEASE;
              rel_pend_nxt = 1'b1;
            end else begin
              push_cmd = rsfp_pkg::CMD_ERROR;
            end
          end
        end
        default: begin
          phase_nxt = PH_LEN;
          count_nxt = '0;
          sum_nxt   = rsfp_pkg::SUM_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN;
      count_r    <= '0;
      sum_r      <= rsfp_pkg::SUM_INIT;
      rel_pend_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      rel_pend_r <= rel_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r <= low_nxt;
  end

endmodule

FILE: sv/rsfp_queue.sv
// Two-entry command queue between the front and back ends of the frame parser.
// Uses rsfp_pkg for the command type.
module rsfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rsfp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rsfp_pkg::cmd_t head
);

  rsfp_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/rsfp_back.sv
// Back end of the frame parser: holds the channel store and the output register.
// Turns queued commands into result items. Uses rsfp_pkg.
module rsfp_back #(
  parameter int unsigned CHANNELS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsfp_pkg::wr_port_t          wr,
  input  logic                        q_valid,
  input  rsfp_pkg::cmd_t              q_head,
  output logic                        q_pop,
  output logic                        rel_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rsfp_pkg::ST_W-1:0]   out_status,
  output logic [rsfp_pkg::CH_W-1:0]   out_index,
  output logic [rsfp_pkg::VAL_W-1:0]  out_value,
  output logic                        out_last
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AW-1:0] K_LAST = AW'(CHANNELS - 1);

  logic [rsfp_pkg::VAL_W-1:0] store_r [CHANNELS];

  logic                        valid_r, valid_nxt;
  logic [rsfp_pkg::ST_W-1:0]   status_r, status_nxt;
  logic [rsfp_pkg::CH_W-1:0]   index_r, index_nxt;
  logic [rsfp_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic                        last_r, last_nxt;
  logic                        rel_act_r, rel_act_nxt;
  logic [AW-1:0]               k_r, k_nxt;
  logic                        out_free;
  logic [AW-1:0]               rd_k;

  assign out_free = !valid_r || out_ready;
  assign rd_k     = rel_act_r ? k_r : '0;

  always_comb begin
    valid_nxt   = valid_r && !out_ready;
    status_nxt  = status_r;
    index_nxt   = index_r;
    value_nxt   = value_r;
    last_nxt    = last_r;
    rel_act_nxt = rel_act_r;
    k_nxt       = k_r;
    q_pop       = 1'b0;
    rel_done    = 1'b0;
    if (out_free && (rel_act_r || q_valid)) begin
      valid_nxt  = 1'b1;
      status_nxt = rsfp_pkg::ST_READY;
      index_nxt  = rsfp_pkg::CH_W'(rd_k);
      value_nxt  = store_r[rd_k];
      last_nxt   = (rd_k == K_LAST);
      if (!rel_act_r) begin
        q_pop = 1'b1;
        case (q_head)
          rsfp_pkg::CMD_BUSY: begin
            status_nxt = rsfp_pkg::ST_BUSY;
            index_nxt  = '0;
            value_nxt  = '0;
            last_nxt   = 1'b1;
          end
          rsfp_pkg::CMD_RELEASE: begin
            if (rd_k == K_LAST) begin
              rel_done = 1'b1;
            end else begin
              rel_act_nxt = 1'b1;
              k_nxt       = rd_k + 1'b1;
            end
          end
          default: begin
            status_nxt = rsfp_pkg::ST_ERROR;
            index_nxt  = '0;
            value_nxt  = '0;
            last_nxt   = 1'b1;
          end
        endcase
      end else begin
        if (rd_k == K_LAST) begin
          rel_done    = 1'b1;
          rel_act_nxt = 1'b0;
          k_nxt       = '0;
        end else begin
          k_nxt = rd_k + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      rel_act_r <= 1'b0;
      k_r       <= '0;
    end else begin
      valid_r   <= valid_nxt;
      rel_act_r <= rel_act_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    index_r  <= index_nxt;
    value_r  <= value_nxt;
    last_r   <= last_nxt;
    if (wr.we) begin
      store_r[wr.ch[AW-1:0]] <= wr.data;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_index  = index_r;
  assign out_value  = value_r;
  assign out_last   = last_r;

endmodule

FILE: sv/rc_servo_frame_parser_unit.sv
// RC servo frame parser top level: front end, command queue and back end.
// Each byte's command is registered in the command queue before its result is loaded into the output register.
// Throughput: one byte per cycle while the output drains; a good frame's final byte
// yields CHANNELS results, read one at a time through the single read port of the
// channel store, with input held off until the last one is loaded.
// Reset (synchronous, rst_n low) restarts the parse and empties queue and output.
module rc_servo_frame_parser_unit #(
  parameter int unsigned CHANNELS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] status, [5:2] channel_index, [21:6] channel_value
  output logic        out_tlast
);

  rsfp_pkg::cmd_t                    push_cmd, q_head;
  rsfp_pkg::wr_port_t                wr;
  logic                              push, q_full, q_valid, q_pop, rel_done;
  logic [rsfp_pkg::ST_W-1:0]         status;
  logic [rsfp_pkg::CH_W-1:0]         index;
  logic [rsfp_pkg::VAL_W-1:0]        value;

  rsfp_front #(.CHANNELS(CHANNELS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .wr       (wr),
    .rel_done (rel_done)
  );

  rsfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  rsfp_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rel_done   (rel_done),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_index  (index),
    .out_value  (value),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, value, index, status};

endmodule

FILE: sv/rsfp_checker.sv
// Port-level checker for the RC servo frame parser, bound to the top level.
// Uses the assertion macros header.
`include "rc_servo_frame_parser_unit_macros.svh"

module rsfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  `RSFP_ASSERT_RST(a_idle_after_reset, !rst_n |=> !out_tvalid, "output valid after reset")
  `RSFP_ASSERT(a_status_legal, out_tvalid |-> out_tdata[1:0] != 2'd3, "illegal status code")
  `RSFP_ASSERT(a_single_shape, (out_tvalid && out_tdata[1:0] != 2'd1) |-> (out_tlast && out_tdata[21:2] == 20'd0), "busy or error item malformed")
  `RSFP_ASSERT(a_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled item changed")

endmodule

bind rc_servo_frame_parser_unit rsfp_checker u_rsfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
